/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/yuyv_pkg.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB package
// Request/response payload types and fixed-point conversion constants.
// ----------------------------------------------------------------------------
package yuyv_pkg;

   localparam int ACC_W     = 22;
   localparam int FRAC_BITS = 10;
   localparam int CHAN_W    = 8;
   localparam int OFF_W     = 10;

   localparam logic signed [ACC_W-1:0] COEF_Y  = 22'sd1192;
   localparam logic signed [ACC_W-1:0] COEF_BU = 22'sd2066;
   localparam logic signed [ACC_W-1:0] COEF_GV = 22'sd833;
   localparam logic signed [ACC_W-1:0] COEF_GU = 22'sd403;
   localparam logic signed [ACC_W-1:0] COEF_RV = 22'sd1634;

   localparam logic signed [OFF_W-1:0] LUMA_OFFSET   = 10'sd16;
   localparam logic signed [OFF_W-1:0] CHROMA_OFFSET = 10'sd128;
   localparam logic signed [ACC_W-1:0] HIGH_LIMIT    = 22'sd256000;
   localparam logic [CHAN_W-1:0]       HIGH_VALUE    = 8'd255;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } req_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

/* src/yuyv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB888 converter
// Converts one YUYV macropixel per request into two RGB888 pixels.
// ----------------------------------------------------------------------------
// One macropixel is accepted every clock cycle while the response side keeps
// up. The input register and the result register bracket the
// constant-coefficient multiply/add and clamp.
// Channels use 10 fractional bits: negative gives 0, above 250.0 gives 255,
// otherwise the fraction is dropped.
module yuyv_to_rgb_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  yuyv_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output yuyv_pkg::rsp_type  rsp_data
);

`include "assert_macros.svh"

   localparam int OFF_W = yuyv_pkg::OFF_W;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   yuyv_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   yuyv_pkg::rsp_type rsp_data_ff;
   yuyv_pkg::rsp_type rsp_data_in;

   logic              out_load;
   logic              req_accept;

   logic signed [OFF_W-1:0] chroma_u;
   logic signed [OFF_W-1:0] chroma_v;
   yuyv_pkg::rgb_type       pixel_first;
   yuyv_pkg::rgb_type       pixel_second;

   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || out_load;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (out_load && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign chroma_u = signed'({{(OFF_W-8){1'b0}}, s1_data_ff.chroma_blue})
                     - yuyv_pkg::CHROMA_OFFSET;
   assign chroma_v = signed'({{(OFF_W-8){1'b0}}, s1_data_ff.chroma_red})
                     - yuyv_pkg::CHROMA_OFFSET;

   yuyv_pixel u_pixel_first (
      .luma     (s1_data_ff.luma_first),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v),
      .pixel    (pixel_first)
   );

   yuyv_pixel u_pixel_second (
      .luma     (s1_data_ff.luma_second),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v),
      .pixel    (pixel_second)
   );

   always_comb begin
      rsp_data_in.red_first    = pixel_first.red;
      rsp_data_in.green_first  = pixel_first.green;
      rsp_data_in.blue_first   = pixel_first.blue;
      rsp_data_in.red_second   = pixel_second.red;
      rsp_data_in.green_second = pixel_second.green;
      rsp_data_in.blue_second  = pixel_second.blue;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_req_loads_stage, clock, reset, req_accept, s1_valid_ff)
   `ASSERT_NEXT(a_stage_moves_out, clock, reset, s1_valid_ff && out_load, rsp_valid_ff)
   `ASSERT_SAME(a_rsp_from_stage, clock, reset, $rose(rsp_valid_ff), $past(s1_valid_ff))
   `ASSERT_HOLDS(a_stall_keeps_stage, clock, reset,
                 !(s1_valid_ff && !out_load && req_ready))

endmodule

/* src/yuyv_pixel.sv */
// ----------------------------------------------------------------------------
// YUYV pixel converter
// Combinational BT.601-style conversion of one luma sample plus shared
// offset chroma into one clamped RGB888 pixel.
// ----------------------------------------------------------------------------
module yuyv_pixel (
   input  logic [7:0]                             luma,
   input  logic signed [yuyv_pkg::OFF_W-1:0]      chroma_u,
   input  logic signed [yuyv_pkg::OFF_W-1:0]      chroma_v,
   output yuyv_pkg::rgb_type                      pixel
);

   localparam int ACC_W = yuyv_pkg::ACC_W;
   localparam int OFF_W = yuyv_pkg::OFF_W;

   logic signed [OFF_W-1:0] luma_off;
   logic signed [ACC_W-1:0] luma_ext;
   logic signed [ACC_W-1:0] u_ext;
   logic signed [ACC_W-1:0] v_ext;
   logic signed [ACC_W-1:0] yy;
   logic signed [ACC_W-1:0] red_acc;
   logic signed [ACC_W-1:0] green_acc;
   logic signed [ACC_W-1:0] blue_acc;

   function automatic logic [yuyv_pkg::CHAN_W-1:0] clamp_channel(
      input logic signed [yuyv_pkg::ACC_W-1:0] acc
   );
      logic [yuyv_pkg::CHAN_W-1:0] res;
      if (acc[yuyv_pkg::ACC_W-1]) begin
         res = '0;
      end else if (acc > yuyv_pkg::HIGH_LIMIT) begin
         res = yuyv_pkg::HIGH_VALUE;
      end else begin
         res = acc[yuyv_pkg::FRAC_BITS +: yuyv_pkg::CHAN_W];
      end
      return res;
   endfunction

   assign luma_off = signed'({{(OFF_W-8){1'b0}}, luma}) - yuyv_pkg::LUMA_OFFSET;
   assign luma_ext = {{(ACC_W-OFF_W){luma_off[OFF_W-1]}}, luma_off};
   assign u_ext    = {{(ACC_W-OFF_W){chroma_u[OFF_W-1]}}, chroma_u};
   assign v_ext    = {{(ACC_W-OFF_W){chroma_v[OFF_W-1]}}, chroma_v};

   assign yy        = luma_ext * yuyv_pkg::COEF_Y;
   assign red_acc   = yy + v_ext * yuyv_pkg::COEF_RV;
   assign green_acc = yy - v_ext * yuyv_pkg::COEF_GV - u_ext * yuyv_pkg::COEF_GU;
   assign blue_acc  = yy + u_ext * yuyv_pkg::COEF_BU;

   assign pixel.red   = clamp_channel(red_acc);
   assign pixel.green = clamp_channel(green_acc);
   assign pixel.blue  = clamp_channel(blue_acc);

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter testbench
// Sends directed and random macropixels through the converter. Random gaps on
// the request side and random stalls on the response side are applied, and
// one drain pause is taken. Every response is checked against a behavioral
// fixed-point model of the BT.601 conversion.
// ----------------------------------------------------------------------------
module tb;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_REQUESTS = 1030;
   localparam int QUIET_TAIL      = 120;
   localparam int DRAIN_POINT     = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;

   localparam int Y_GAIN      = 1192;
   localparam int BU_GAIN     = 2066;
   localparam int GV_GAIN     = 833;
   localparam int GU_GAIN     = 403;
   localparam int RV_GAIN     = 1634;
   localparam int Y_BIAS      = 16;
   localparam int C_BIAS      = 128;
   localparam int SAT_LEVEL   = 256000;
   localparam int FRACTION    = 10;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   yuyv_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   yuyv_pkg::rsp_type rsp_data;

   yuyv_pkg::req_type pending_requests[$];
   yuyv_pkg::rsp_type expected_pixels[$];
   int      accepted_count = 0;
   int      error_count    = 0;
   int      send_gap       = 0;
   int      stall_left     = 0;
   int      idle_cycles    = 0;

   always #HALF_PERIOD clock = ~clock;

   yuyv_to_rgb_converter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic logic [7:0] saturate_channel(int acc);
      if (acc < 0) begin
         return 8'd0;
      end
      if (acc > SAT_LEVEL) begin
         return 8'd255;
      end
      return 8'(acc >>> FRACTION);
   endfunction

   function automatic yuyv_pkg::rsp_type convert_macropixel(yuyv_pkg::req_type px);
      yuyv_pkg::rsp_type rgb;
      int      u;
      int      v;
      int      y0;
      int      y1;
      u  = int'(px.chroma_blue) - C_BIAS;
      v  = int'(px.chroma_red) - C_BIAS;
      y0 = Y_GAIN * (int'(px.luma_first) - Y_BIAS);
      y1 = Y_GAIN * (int'(px.luma_second) - Y_BIAS);
      rgb.red_first    = saturate_channel(y0 + RV_GAIN * v);
      rgb.green_first  = saturate_channel(y0 - GV_GAIN * v - GU_GAIN * u);
      rgb.blue_first   = saturate_channel(y0 + BU_GAIN * u);
      rgb.red_second   = saturate_channel(y1 + RV_GAIN * v);
      rgb.green_second = saturate_channel(y1 - GV_GAIN * v - GU_GAIN * u);
      rgb.blue_second  = saturate_channel(y1 + BU_GAIN * u);
      return rgb;
   endfunction

   function automatic logic [7:0] pick_sample();
      logic [7:0] corners[14] = '{0, 1, 15, 16, 17, 127, 128, 129, 230, 231, 235, 240,
                                  254, 255};
      if ($urandom_range(0, 3) == 0) begin
         return corners[$urandom_range(0, 13)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic compare_pixels(yuyv_pkg::rsp_type got, yuyv_pkg::rsp_type want);
      if (got.red_first !== want.red_first) begin
         $error("red_first: expected %0d, got %0d", want.red_first, got.red_first);
         error_count++;
      end
      if (got.green_first !== want.green_first) begin
         $error("green_first: expected %0d, got %0d", want.green_first, got.green_first);
         error_count++;
      end
      if (got.blue_first !== want.blue_first) begin
         $error("blue_first: expected %0d, got %0d", want.blue_first, got.blue_first);
         error_count++;
      end
      if (got.red_second !== want.red_second) begin
         $error("red_second: expected %0d, got %0d", want.red_second, got.red_second);
         error_count++;
      end
      if (got.green_second !== want.green_second) begin
         $error("green_second: expected %0d, got %0d", want.green_second,
                got.green_second);
         error_count++;
      end
      if (got.blue_second !== want.blue_second) begin
         $error("blue_second: expected %0d, got %0d", want.blue_second, got.blue_second);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(convert_macropixel(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (accepted_count == DRAIN_POINT && expected_pixels.size() != 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests.size() > QUIET_TAIL &&
                         $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               error_count++;
            end else begin
               compare_pixels(rsp_data, expected_pixels.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      yuyv_pkg::req_type item;
      // black, white, full-scale chroma, saturation edges on each channel
      pending_requests.push_back('{8'd0,   8'd0,   8'd0,   8'd0});
      pending_requests.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
      pending_requests.push_back('{8'd16,  8'd128, 8'd16,  8'd128});
      pending_requests.push_back('{8'd235, 8'd128, 8'd235, 8'd128});
      pending_requests.push_back('{8'd230, 8'd128, 8'd231, 8'd128});
      pending_requests.push_back('{8'd0,   8'd128, 8'd255, 8'd128});
      pending_requests.push_back('{8'd128, 8'd0,   8'd128, 8'd255});
      pending_requests.push_back('{8'd128, 8'd255, 8'd128, 8'd0});
      pending_requests.push_back('{8'd255, 8'd0,   8'd255, 8'd0});
      pending_requests.push_back('{8'd0,   8'd255, 8'd0,   8'd255});
      pending_requests.push_back('{8'd255, 8'd255, 8'd0,   8'd0});
      pending_requests.push_back('{8'd0,   8'd0,   8'd255, 8'd255});
      pending_requests.push_back('{8'd99,  8'd0,   8'd98,  8'd0});
      pending_requests.push_back('{8'd200, 8'd128, 8'd201, 8'd150});
      pending_requests.push_back('{8'd120, 8'd255, 8'd119, 8'd128});
      pending_requests.push_back('{8'd15,  8'd127, 8'd17,  8'd129});
      pending_requests.push_back('{8'd170, 8'd85,  8'd85,  8'd170});
      pending_requests.push_back('{8'd81,  8'd90,  8'd145, 8'd240});
      pending_requests.push_back('{8'd240, 8'd16,  8'd41,  8'd110});
      pending_requests.push_back('{8'd254, 8'd1,   8'd1,   8'd254});
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         item.luma_first  = pick_sample();
         item.chroma_blue = pick_sample();
         item.luma_second = pick_sample();
         item.chroma_red  = pick_sample();
         pending_requests.push_back(item);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
